### hdl/string_to_integer_parser_macros.svh
// Assertion macros for the string to integer parser.
// Used by the top level; no other dependencies.
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define STP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/stp_pkg.sv
// Package for the string to integer parser: beat types, config type,
// register indexes and character codes. No dependencies.
package stp_pkg;

	localparam int MAX_POS_DEF = 1023;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int VALUE_W     = 64;
	localparam int STOP_W      = 10;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_BAD   = 6'd1;

	localparam logic [DIGIT_W-1:0] NOT_DIGIT = 6'd63;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [STOP_W-1:0]  stop_pos;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               signed_mode;
	} cfg_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
	} char_class_t;

endpackage

### hdl/stp_decode.sv
// Character classifier: digit value (case-blind, radix up to 36) and sign,
// zero and x flags. Depends on stp_pkg.
module stp_decode import stp_pkg::*; (
	input  logic [7:0]  ch,
	output char_class_t cls
);

	logic [7:0] lc;

	always_comb begin
		lc = (ch >= CH_UP_A && ch <= CH_UP_Z) ? ch + CASE_OFS : ch;
		if (lc >= CH_ZERO && lc <= CH_NINE) begin
			cls.digit = DIGIT_W'(lc - CH_ZERO);
		end else if (lc >= CH_LO_A && lc <= CH_LO_Z) begin
			cls.digit = DIGIT_W'(lc - CH_LO_A + 8'd10);
		end else begin
			cls.digit = NOT_DIGIT;
		end
		cls.is_plus  = (ch == CH_PLUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_zero  = (ch == CH_ZERO);
		cls.is_x     = (lc == CH_LO_X);
	end

endmodule

### hdl/stp_engine.sv
// Parse state and one-character step: sign, radix detection, multiply-add
// accumulation and result formation. Depends on stp_pkg and stp_decode.
module stp_engine import stp_pkg::*; #(
	parameter int MAX_POS = MAX_POS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      emit,
	output out_item_t result
);

	localparam int POS_W = $clog2(MAX_POS + 1);
	localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_POS);
	localparam int PROD_W = VALUE_W + RADIX_W;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_HEX    = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
		return (p >= POS_SAT) ? POS_SAT : p + 1'b1;
	endfunction

	logic [2:0]         phase_q, phase_n, ph0;
	logic [VALUE_W-1:0] acc_q, acc_n, acc0;
	logic               neg_q, neg_n, neg0;
	logic [POS_W-1:0]   pos_q, pos_n, pos0, cur;
	logic [RADIX_W-1:0] wr_q, wr_n, wr0, wr_eff, r_mul;
	logic               wrap_q, wrap_n, wrap0, wrap_step;
	logic [PROD_W-1:0]  prod;
	logic               digit_ok, bad_radix;
	char_class_t        cls;

	stp_decode u_dec (
		.ch  (item.ch),
		.cls (cls)
	);

	// a first beat restarts the parse before the character is looked at
	always_comb begin
		bad_radix = (cfg.radix == RADIX_BAD) || (cfg.radix > RADIX_MAX);
		if (item.first) begin
			ph0   = PH_START;
			acc0  = '0;
			neg0  = 1'b0;
			pos0  = '0;
			wr0   = cfg.radix;
			wrap0 = 1'b0;
		end else begin
			ph0   = phase_q;
			acc0  = acc_q;
			neg0  = neg_q;
			pos0  = pos_q;
			wr0   = wr_q;
			wrap0 = wrap_q;
		end
		wr_eff = (wr0 == '0) ? RADIX_DEC : wr0;
		case (ph0)
			PH_ZERO: r_mul = RADIX_OCT;
			PH_HEX:  r_mul = RADIX_HEX;
			default: r_mul = wr_eff;
		endcase
		digit_ok  = cls.digit < r_mul;
		prod      = {{RADIX_W{1'b0}}, acc0} * {{VALUE_W{1'b0}}, r_mul}
			+ PROD_W'(cls.digit);
		wrap_step = wrap0 | (|prod[PROD_W-1:VALUE_W]);
		// in the hex phase the stored position is the x, the current char is one on
		cur = (ph0 == PH_HEX) ? sat_inc(pos0) : pos0;
	end

	always_comb begin
		phase_n = ph0;
		acc_n   = acc0;
		neg_n   = neg0;
		pos_n   = pos0;
		wr_n    = wr0;
		wrap_n  = wrap0;
		emit    = 1'b0;
		result  = '0;
		if (item.first && bad_radix) begin
			emit    = 1'b1;
			phase_n = PH_DONE;
		end else if (ph0 != PH_IDLE && ph0 != PH_DONE) begin
			pos_n = sat_inc(cur);
			case (ph0)
				PH_START, PH_SIGNED: begin
					if (ph0 == PH_START && cls.is_plus) begin
						phase_n = PH_SIGNED;
					end else if (ph0 == PH_START && cls.is_minus && cfg.signed_mode) begin
						phase_n = PH_SIGNED;
						neg_n   = 1'b1;
					end else if (wr0 == '0 && cls.is_zero) begin
						phase_n = PH_ZERO;
					end else begin
						wr_n = wr_eff;
						if (digit_ok) begin
							acc_n   = prod[VALUE_W-1:0];
							wrap_n  = wrap_step;
							phase_n = PH_DIGITS;
						end else begin
							emit    = 1'b1;
							phase_n = PH_DONE;
						end
					end
				end
				PH_ZERO: begin
					if (cls.is_x) begin
						wr_n    = RADIX_HEX;
						phase_n = PH_HEX;
						pos_n   = cur;
					end else begin
						wr_n = RADIX_OCT;
						if (digit_ok) begin
							acc_n   = prod[VALUE_W-1:0];
							wrap_n  = wrap_step;
							phase_n = PH_DIGITS;
						end else begin
							emit            = 1'b1;
							phase_n         = PH_DONE;
							result.value    = neg0 ? ~acc0 + 1'b1 : acc0;
							result.stop_pos = STOP_W'(cur);
							result.overflow = wrap0;
						end
					end
				end
				PH_HEX: begin
					if (digit_ok) begin
						acc_n   = prod[VALUE_W-1:0];
						wrap_n  = wrap_step;
						phase_n = PH_DIGITS;
					end else begin
						// "0x" with no hex digit stops at the x
						emit            = 1'b1;
						phase_n         = PH_DONE;
						result.stop_pos = STOP_W'(pos0);
					end
				end
				default: begin
					if (digit_ok) begin
						acc_n  = prod[VALUE_W-1:0];
						wrap_n = wrap_step;
					end else begin
						emit            = 1'b1;
						phase_n         = PH_DONE;
						result.value    = neg0 ? ~acc0 + 1'b1 : acc0;
						result.stop_pos = STOP_W'(cur);
						result.overflow = wrap0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			pos_q   <= '0;
			wr_q    <= '0;
			wrap_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			pos_q   <= pos_n;
			wr_q    <= wr_n;
			wrap_q  <= wrap_n;
		end
	end

endmodule

### hdl/string_to_integer_parser.sv
// Streaming strtol-style parser, one character per beat, radix 2 to 36 or auto.
// A result beat is offered right after the edge where its char leaves s1.
// One character per cycle unless stalled; combinational 64 x 6 bit multiply-add.
// Input register and result register stall only when a result cannot be delivered.
// Reset: radix 10, signed mode on, parser idle, both registers empty.
// Depends on stp_pkg, stp_engine, stp_decode and string_to_integer_parser_macros.svh.
`include "string_to_integer_parser_macros.svh"
module string_to_integer_parser import stp_pkg::*; #(
	parameter int MAX_POS = MAX_POS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_data_s2;
	logic      out_valid_s2;
	logic      fire, emit;
	out_item_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix       <= RADIX_RESET;
			cfg_q.signed_mode <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_RADIX) begin
				cfg_q.radix <= cfg_wdata[RADIX_W-1:0];
			end
			if (cfg_addr == CFG_SIGNED) begin
				cfg_q.signed_mode <= cfg_wdata[0];
			end
		end
	end

	// beats with no result move on even while the result register is stalled
	assign fire     = valid_s1 && (!emit || !out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	stp_engine #(
		.MAX_POS (MAX_POS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fire && emit) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_data_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	`STP_ASSERT_NEXT(a_result_loaded, clk, arst_n, fire && emit,
		out_valid && out_data == $past(result), "result beat not loaded")
	`STP_ASSERT_NOW(a_stall_needs_item, clk, arst_n, in_stall,
		valid_s1 && emit && out_valid && out_stall, "input stalled without cause")
	`STP_ASSERT_NEXT(a_result_drains, clk, arst_n, out_valid && !out_stall && !(fire && emit),
		!out_valid, "result beat repeated")
	`STP_ASSERT_NOW(a_bad_radix_zero, clk, arst_n,
		fire && item_s1.first && (cfg_q.radix == RADIX_BAD || cfg_q.radix > RADIX_MAX),
		emit && result == '0, "invalid radix must give zero at once")

endmodule

### tb/tb_string_to_integer_parser.sv
// Testbench for string_to_integer_parser: directed and random character streams, with
// its own parser model predicting each result beat's value, stop position and overflow flag.
// Depends on stp_pkg and the string_to_integer_parser RTL.
module tb_string_to_integer_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import stp_pkg::*;

	localparam int SETTLE_CYCLES = 6;

	typedef enum logic [2:0] {
		PH_IDLE, PH_START, PH_SIGNED, PH_ZERO, PH_HEX, PH_DIGITS, PH_DONE
	} parse_phase_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	string_to_integer_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// parser model state
	logic [RADIX_W-1:0] m_radix;
	logic               m_signed;
	parse_phase_t       m_phase;
	logic [63:0]        m_acc;
	logic               m_neg;
	logic [9:0]         m_pos;
	logic [RADIX_W-1:0] m_wradix;
	logic               m_wrap;

	out_item_t pending_results[$];
	int        mismatches = 0;
	int        chars_sent = 0;
	int        rx_hold_len = 0;
	bit        calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [5:0] char_digit(logic [7:0] c);
		logic [7:0] lc;
		lc = c;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			lc = c + CASE_OFS;
		if (lc >= CH_ZERO && lc <= CH_NINE)
			return 6'(lc - CH_ZERO);
		if (lc >= CH_LO_A && lc <= CH_LO_Z)
			return 6'(lc - CH_LO_A + 8'd10);
		return NOT_DIGIT;
	endfunction

	function automatic logic [9:0] pos_next(logic [9:0] p);
		return (p >= MAX_POS_DEF) ? 10'(MAX_POS_DEF) : p + 10'd1;
	endfunction

	function void model_reset();
		m_radix  = RADIX_RESET;
		m_signed = 1'b1;
		m_phase  = PH_IDLE;
		m_acc    = '0;
		m_neg    = 1'b0;
		m_pos    = '0;
		m_wradix = '0;
		m_wrap   = 1'b0;
	endfunction

	function void push_result(logic [63:0] v, logic [9:0] p, logic o);
		out_item_t r;
		r.value    = v;
		r.stop_pos = p;
		r.overflow = o;
		pending_results.push_back(r);
		m_phase = PH_DONE;
	endfunction

	function void add_digit(logic [5:0] d);
		logic [63:0] r;
		logic [63:0] lim;
		r   = {58'd0, m_wradix};
		lim = (64'hFFFF_FFFF_FFFF_FFFF - {58'd0, d}) / r;
		if (m_acc > lim)
			m_wrap = 1'b1;
		m_acc = m_acc * r + {58'd0, d};
	endfunction

	// one accepted character through the parser model
	function void parse_char(logic [7:0] c, logic first);
		logic [5:0] d;
		logic [9:0] cur;
		logic [9:0] xpos;
		d    = char_digit(c);
		xpos = '0;
		if (first) begin
			m_acc    = '0;
			m_neg    = 1'b0;
			m_wrap   = 1'b0;
			m_pos    = '0;
			m_phase  = PH_START;
			m_wradix = m_radix;
			if (m_radix == RADIX_BAD || m_radix > RADIX_MAX) begin
				push_result('0, '0, 1'b0);
				return;
			end
		end
		if (m_phase == PH_IDLE || m_phase == PH_DONE)
			return;
		// after the prefix, position still points at the 'x'
		if (m_phase == PH_HEX) begin
			xpos = m_pos;
			cur  = pos_next(m_pos);
		end else begin
			cur = m_pos;
		end
		m_pos = pos_next(cur);
		case (m_phase)
			PH_START, PH_SIGNED: begin
				if (m_phase == PH_START) begin
					if (c == CH_PLUS) begin
						m_phase = PH_SIGNED;
						return;
					end
					if (c == CH_MINUS && m_signed) begin
						m_neg   = 1'b1;
						m_phase = PH_SIGNED;
						return;
					end
				end
				if (m_wradix == '0) begin
					if (c == CH_ZERO) begin
						m_phase = PH_ZERO;
						return;
					end
					m_wradix = RADIX_DEC;
				end
				if (d < m_wradix) begin
					add_digit(d);
					m_phase = PH_DIGITS;
				end else begin
					push_result('0, '0, 1'b0);
				end
				return;
			end
			PH_ZERO: begin
				if (c == CH_LO_X || c == (CH_LO_X - CASE_OFS)) begin
					m_wradix = RADIX_HEX;
					m_phase  = PH_HEX;
					m_pos    = cur;
					return;
				end
				m_wradix = RADIX_OCT;
				m_phase  = PH_DIGITS;
			end
			PH_HEX: begin
				if (d < 6'd16) begin
					add_digit(d);
					m_phase = PH_DIGITS;
				end else begin
					push_result('0, xpos, 1'b0);
				end
				return;
			end
			default: ;
		endcase
		if (d < m_wradix)
			add_digit(d);
		else
			push_result(m_neg ? 64'd0 - m_acc : m_acc, cur, m_wrap);
	endfunction

	function automatic logic [7:0] digit_char(int v);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
	endfunction

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result value=%h stop_pos=%0d overflow=%b",
						$realtime, out_data.value, out_data.stop_pos, out_data.overflow);
			end else begin
				want = pending_results.pop_front();
				if (out_data.value !== want.value || out_data.stop_pos !== want.stop_pos ||
						out_data.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch expected %h/%0d/%b got %h/%0d/%b", $realtime,
							want.value, want.stop_pos, want.overflow,
							out_data.value, out_data.stop_pos, out_data.overflow);
				end
			end
		end
	end

	// result side: random stalls, or a long hold-off on request
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				hold        = rx_hold_len;
				rx_hold_len = 0;
				out_stall   = 1'b1;
				repeat (hold - 1) @(negedge clk);
			end else begin
				out_stall = !calm && ($urandom_range(99) < 11);
			end
		end
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_char(input logic [7:0] c, input logic f);
		while (!calm && $urandom_range(99) < 11) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data.ch    = c;
		in_data.first = f;
		in_valid      = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_char(c, f);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input bit first_flag);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], first_flag && i == 0);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = data;
		@(posedge clk);
		if (idx == CFG_RADIX)
			m_radix = data;
		else
			m_signed = data[0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly well-formed numbers for the current radix, some raw noise
	task automatic send_word();
		logic [7:0] w[$];
		int         r;
		int         nd;
		int         pick;
		int         k;
		if ($urandom_range(99) < 12) begin
			k = $urandom_range(1, 4);
			repeat (k) send_char(8'($urandom_range(255)), $urandom_range(99) < 40);
			return;
		end
		r = (m_radix >= 2 && m_radix <= RADIX_MAX) ? int'(m_radix) : 10;
		pick = $urandom_range(9);
		if (pick < 3)
			w.push_back(CH_PLUS);
		else if (pick < 6)
			w.push_back(CH_MINUS);
		if (pick == 0)
			w.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
		if (m_radix == '0) begin
			pick = $urandom_range(2);
			if (pick == 0) begin
				w.push_back(CH_ZERO);
				w.push_back($urandom_range(1) ? CH_LO_X : CH_LO_X - CASE_OFS);
				r = 16;
			end else if (pick == 1) begin
				w.push_back(CH_ZERO);
				r = 8;
			end else begin
				w.push_back(digit_char($urandom_range(1, 9)));
				r = 10;
			end
		end
		pick = $urandom_range(99);
		nd = pick < 70 ? $urandom_range(0, 6) : pick < 90 ? $urandom_range(7, 20) :
			$urandom_range(21, 70);
		repeat (nd) w.push_back(digit_char($urandom_range(r - 1)));
		// sometimes no terminator, so the next word cuts the parse short
		if ($urandom_range(9) != 0)
			w.push_back(8'($urandom_range(255)));
		foreach (w[i])
			send_char(w[i], i == 0);
		k = ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
		repeat (k) send_char(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic test_directed_basic();
		send_text("5", 1'b0);
		send_text("-42,", 1'b1);
		send_text("9", 1'b0);
		send_text("++5", 1'b1);
		send_text("q", 1'b1);
		send_text("12", 1'b1);
		send_text("7.", 1'b1);
		drain();
	endtask

	task automatic test_directed_auto_radix();
		set_reg(CFG_RADIX, '0);
		send_text("0xg", 1'b1);
		send_text("0Xf!", 1'b1);
		send_text("08", 1'b1);
		drain();
	endtask

	task automatic test_directed_modes();
		set_reg(CFG_RADIX, RADIX_BAD);
		send_text("73", 1'b1);
		drain();
		set_reg(CFG_RADIX, RADIX_MAX);
		set_reg(CFG_SIGNED, 6'd0);
		send_text("-5", 1'b1);
		send_text("zZ.", 1'b1);
		drain();
		set_reg(CFG_RADIX, 6'd63);
		send_text("z", 1'b1);
		drain();
	endtask

	task automatic test_random_strings();
		logic [RADIX_W-1:0] radix_plan[8] = '{6'd0, 6'd2, 6'd36, 6'd1, 6'd37, 6'd63, 6'd16, 6'd10};
		logic [RADIX_W-1:0] rdx;
		logic               sgn;
		int                 start;
		int                 p;
		start = chars_sent;
		p     = 0;
		while (chars_sent - start < 120) begin
			drain();
			if (p < 8) begin
				rdx = radix_plan[p];
				sgn = p[0];
			end else begin
				rdx = ($urandom_range(99) < 80) ? 6'($urandom_range(2, 36)) :
					6'($urandom_range(63));
				sgn = 1'($urandom_range(1));
			end
			set_reg(CFG_RADIX, rdx);
			set_reg(CFG_SIGNED, {5'($urandom_range(31)), sgn});
			repeat (3) send_word();
			p++;
		end
		drain();
	endtask

	task automatic test_no_idle();
		int start;
		set_reg(CFG_RADIX, '0);
		set_reg(CFG_SIGNED, 6'd1);
		calm  = 1'b1;
		start = chars_sent;
		while (chars_sent - start < 50)
			send_word();
		drain();
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		set_reg(CFG_RADIX, RADIX_DEC);
		rx_hold_len = 300;
		repeat (5) send_word();
		drain();
	endtask

	// positions saturate past the top index; values wrap
	task automatic test_long_strings();
		set_reg(CFG_RADIX, RADIX_DEC);
		set_reg(CFG_SIGNED, 6'd1);
		send_char(CH_MINUS, 1'b1);
		repeat (1030) send_char(digit_char($urandom_range(9)), 1'b0);
		send_char(CH_PLUS, 1'b0);
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		model_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_basic();
		test_directed_auto_radix();
		test_directed_modes();
		test_random_strings();
		test_no_idle();
		test_backpressure();
		test_long_strings();

		drain();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			$display("%0d expected results never arrived", pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/stp_pkg.sv
hdl/stp_decode.sv
hdl/stp_engine.sv
hdl/string_to_integer_parser.sv
tb/tb_string_to_integer_parser.sv
